// File: src/qfe_pkg.sv
// Shared types and constants for the quadratic form engine.
`timescale 1ns / 1ps
`default_nettype none
package qfe_pkg;
  localparam int NUM_VARS_D   = 8;
  localparam int VALUE_BITS_D = 16;
  localparam int COEF_BITS_D  = 16;
  localparam int OUT_BITS     = 54;
  localparam int MASK_BITS    = 8;
  localparam int IDX_BITS     = 3;

  typedef enum logic [2:0] {
    REQ_ADD  = 3'd0,
    REQ_SUB  = 3'd1,
    REQ_CLR  = 3'd2,
    REQ_LOAD = 3'd3,
    REQ_EVAL = 3'd4
  } req_t;

  typedef struct packed {
    logic                 upd_inc;
    logic                 upd_dec;
    logic                 clr;
    logic                 ld_en;
    logic [IDX_BITS-1:0]  ld_idx;
    logic [MASK_BITS-1:0] row_mask;
    logic [MASK_BITS-1:0] col_mask;
    logic                 rot;
    logic                 row_step;
  } cell_ctrl_t;
endpackage
`default_nettype wire

// File: src/quadratic_form_engine.sv
// Top level of the quadratic form engine: request decode, cell ring and evaluation sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Holds an NUM_VARS x NUM_VARS signed coefficient matrix and NUM_VARS signed
// variables in a ring of row cells, one row per cell. Add, subtract, clear and
// load requests update the cells in parallel (cells saturate at COEF_BITS,
// loads saturate at VALUE_BITS). Evaluate rotates the coefficient rows and the
// column variables through the ring so that one term reaches the head cell per
// cycle, feeding a single shared four-stage multiply-accumulate: an evaluate
// feeds all NUM_VARS*NUM_VARS terms and then drains the pipeline before its
// 54-bit saturated result word appears on the out channel; the next request is
// taken once the engine is idle again. The result sits in an output register;
// other requests are still taken while it waits, and only a further evaluate
// holds off until the pending word is taken.
module quadratic_form_engine #(
  parameter int NUM_VARS   = qfe_pkg::NUM_VARS_D,
  parameter int VALUE_BITS = qfe_pkg::VALUE_BITS_D,
  parameter int COEF_BITS  = qfe_pkg::COEF_BITS_D
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0]                            in_req_type,
  input  logic [7:0]                            in_row_mask,
  input  logic [7:0]                            in_col_mask,
  input  logic [2:0]                            in_var_index,
  input  logic signed [15:0]                    in_var_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [qfe_pkg::OUT_BITS-1:0]   out_form_value
);
  import qfe_pkg::*;

  localparam int CW = $clog2(NUM_VARS);
  localparam logic [CW-1:0] LAST = CW'(NUM_VARS - 1);
  localparam logic signed [24:0] V_MAX = 25'((1 << (VALUE_BITS - 1)) - 1);
  localparam logic signed [24:0] V_MIN = -V_MAX - 1;

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_DRAIN} state_t;

  state_t                             state_r;
  logic [CW-1:0]                      col_r, row_r;
  logic                               out_valid_r;
  logic signed [OUT_BITS-1:0]         out_form_r;
  logic                               accept, start, feed, mac_busy;
  logic signed [OUT_BITS-1:0]         mac_acc;
  logic signed [24:0]                 vx;
  logic signed [VALUE_BITS-1:0]       ld_val;
  cell_ctrl_t                         ctrl;

  logic [NUM_VARS-1:0][NUM_VARS-1:0][COEF_BITS-1:0] rows;
  logic [NUM_VARS-1:0][VALUE_BITS-1:0]              xr, xc;

  // Hold off a second evaluate while a result word is still pending.
  assign in_ready = (state_r == ST_IDLE) &&
                    !(out_valid_r && (in_req_type == REQ_EVAL));
  assign accept   = in_valid && in_ready;
  assign start    = accept && (in_req_type == REQ_EVAL);
  assign feed     = (state_r == ST_EVAL);

  // Saturate the load value into the variable width.
  always_comb begin
    vx = 25'(in_var_value);
    if (vx > V_MAX)      ld_val = V_MAX[VALUE_BITS-1:0];
    else if (vx < V_MIN) ld_val = V_MIN[VALUE_BITS-1:0];
    else                 ld_val = vx[VALUE_BITS-1:0];
  end

  always_comb begin
    ctrl          = '0;
    ctrl.upd_inc  = accept && (in_req_type == REQ_ADD);
    ctrl.upd_dec  = accept && (in_req_type == REQ_SUB);
    ctrl.clr      = accept && (in_req_type == REQ_CLR);
    ctrl.ld_en    = accept && (in_req_type == REQ_LOAD);
    ctrl.ld_idx   = in_var_index;
    ctrl.row_mask = in_row_mask;
    ctrl.col_mask = in_col_mask;
    // Advance the column ring every cycle of an evaluate; step whole rows at each row end.
    ctrl.rot      = feed;
    ctrl.row_step = feed && (col_r == LAST);
  end

  for (genvar k = 0; k < NUM_VARS; k++) begin : g_cell
    qfe_cell #(
      .NUM_VARS  (NUM_VARS),
      .VALUE_BITS(VALUE_BITS),
      .COEF_BITS (COEF_BITS),
      .IDX       (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .ld_val(ld_val),
      .nb_row(rows[(k + 1) % NUM_VARS]),
      .nb_xr (xr[(k + 1) % NUM_VARS]),
      .nb_xc (xc[(k + 1) % NUM_VARS]),
      .row_q (rows[k]),
      .xr_q  (xr[k]),
      .xc_q  (xc[k])
    );
  end

  // The head cell presents a(i,j), x(i) and x(j) for the current term.
  qfe_mac #(
    .VALUE_BITS(VALUE_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .in_v (feed),
    .coef ($signed(rows[0][0])),
    .xi   ($signed(xr[0])),
    .xj   ($signed(xc[0])),
    .busy (mac_busy),
    .acc  (mac_acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      out_form_r  <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          col_r <= '0;
          row_r <= '0;
          if (start) state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (col_r == LAST) begin
            col_r <= '0;
            if (row_r == LAST) state_r <= ST_DRAIN;
            else               row_r   <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          // Drop into idle once the last term has been accumulated.
          if (!mac_busy) begin
            out_valid_r <= 1'b1;
            out_form_r  <= mac_acc;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_form_value = out_form_r;
endmodule
`default_nettype wire

// File: src/qfe_cell.sv
// One row cell: a coefficient row, its row variable and a rotating column variable.
`timescale 1ns / 1ps
`default_nettype none
module qfe_cell #(
  parameter int NUM_VARS   = qfe_pkg::NUM_VARS_D,
  parameter int VALUE_BITS = qfe_pkg::VALUE_BITS_D,
  parameter int COEF_BITS  = qfe_pkg::COEF_BITS_D,
  parameter int IDX        = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  qfe_pkg::cell_ctrl_t                   ctrl,
  input  logic signed [VALUE_BITS-1:0]          ld_val,
  input  logic [NUM_VARS-1:0][COEF_BITS-1:0]    nb_row,
  input  logic signed [VALUE_BITS-1:0]          nb_xr,
  input  logic signed [VALUE_BITS-1:0]          nb_xc,
  output logic [NUM_VARS-1:0][COEF_BITS-1:0]    row_q,
  output logic signed [VALUE_BITS-1:0]          xr_q,
  output logic signed [VALUE_BITS-1:0]          xc_q
);
  import qfe_pkg::*;

  localparam logic [COEF_BITS-1:0] CMAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic [COEF_BITS-1:0] CMIN = {1'b1, {(COEF_BITS-1){1'b0}}};

  logic [NUM_VARS-1:0][COEF_BITS-1:0] row_r, row_nxt;
  logic signed [VALUE_BITS-1:0]       xr_r, xr_nxt, xc_r, xc_nxt;
  logic                               row_sel, ld_hit;

  always_comb begin
    row_sel = (IDX < MASK_BITS) ? ctrl.row_mask[IDX_BITS'(IDX)] : 1'b0;
    ld_hit  = ctrl.ld_en && (IDX < MASK_BITS) && (ctrl.ld_idx == IDX_BITS'(IDX));
    row_nxt = row_r;
    xr_nxt  = xr_r;
    xc_nxt  = xc_r;
    if (ctrl.clr) begin
      row_nxt = '0;
    end else if (row_sel && (ctrl.upd_inc || ctrl.upd_dec)) begin
      for (int j = 0; j < NUM_VARS; j++) begin
        if ((j < MASK_BITS) && ctrl.col_mask[IDX_BITS'(j)]) begin
          if (ctrl.upd_inc && row_r[j] != CMAX) row_nxt[j] = row_r[j] + 1'b1;
          if (ctrl.upd_dec && row_r[j] != CMIN) row_nxt[j] = row_r[j] - 1'b1;
        end
      end
    end
    if (ctrl.rot) begin
      xc_nxt = nb_xc;
      for (int j = 0; j < NUM_VARS; j++) begin
        row_nxt[j] = ctrl.row_step ? nb_row[(j + 1) % NUM_VARS] : row_r[(j + 1) % NUM_VARS];
      end
      if (ctrl.row_step) xr_nxt = nb_xr;
    end
    if (ld_hit) begin
      xr_nxt = ld_val;
      xc_nxt = ld_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      xr_r  <= '0;
      xc_r  <= '0;
    end else begin
      row_r <= row_nxt;
      xr_r  <= xr_nxt;
      xc_r  <= xc_nxt;
    end
  end

  assign row_q = row_r;
  assign xr_q  = xr_r;
  assign xc_q  = xc_r;
endmodule
`default_nettype wire

// File: src/qfe_mac.sv
// Pipelined saturating multiply-accumulate of coefficient times two variables.
`timescale 1ns / 1ps
`default_nettype none
module qfe_mac #(
  parameter int VALUE_BITS = qfe_pkg::VALUE_BITS_D,
  parameter int COEF_BITS  = qfe_pkg::COEF_BITS_D
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               in_v,
  input  logic signed [COEF_BITS-1:0]        coef,
  input  logic signed [VALUE_BITS-1:0]       xi,
  input  logic signed [VALUE_BITS-1:0]       xj,
  output logic                               busy,
  output logic signed [qfe_pkg::OUT_BITS-1:0] acc
);
  import qfe_pkg::*;

  localparam int XW  = 2 * VALUE_BITS;
  localparam int TW  = COEF_BITS + XW + 1;
  localparam int SW  = ((TW > OUT_BITS) ? TW : OUT_BITS) + 1;
  localparam int PLW = COEF_BITS + VALUE_BITS + 1;
  localparam int PHW = COEF_BITS + VALUE_BITS;
  localparam logic signed [SW-1:0] T_MAX = SW'({1'b0, {(OUT_BITS-1){1'b1}}});
  localparam logic signed [SW-1:0] T_MIN = -T_MAX - 1;
  localparam logic signed [OUT_BITS:0] A_MAX = (OUT_BITS+1)'({1'b0, {(OUT_BITS-1){1'b1}}});
  localparam logic signed [OUT_BITS:0] A_MIN = -A_MAX - 1;

  logic                                  v1_r, v2_r, v3_r;
  logic signed [COEF_BITS-1:0]           a1_r;
  logic signed [XW-1:0]                  xx_r;
  logic signed [PLW-1:0]                 plo_r;
  logic signed [PHW-1:0]                 phi_r;
  logic signed [OUT_BITS-1:0]            term_r, acc_r;
  logic signed [SW-1:0]                  term_full;
  logic signed [OUT_BITS:0]              sum;

  always_comb begin
    term_full = (SW'(phi_r) <<< VALUE_BITS) + SW'(plo_r);
    sum       = (OUT_BITS+1)'(acc_r) + (OUT_BITS+1)'(term_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (start) begin
        acc_r <= '0;
      end else if (v3_r) begin
        if (sum > A_MAX)      acc_r <= A_MAX[OUT_BITS-1:0];
        else if (sum < A_MIN) acc_r <= A_MIN[OUT_BITS-1:0];
        else                  acc_r <= sum[OUT_BITS-1:0];
      end
    end
    a1_r  <= coef;
    xx_r  <= XW'(xi) * XW'(xj);
    plo_r <= PLW'(a1_r) * PLW'($signed({1'b0, xx_r[VALUE_BITS-1:0]}));
    phi_r <= PHW'(a1_r) * PHW'($signed(xx_r[XW-1:VALUE_BITS]));
    if (term_full > T_MAX)      term_r <= T_MAX[OUT_BITS-1:0];
    else if (term_full < T_MIN) term_r <= T_MIN[OUT_BITS-1:0];
    else                        term_r <= term_full[OUT_BITS-1:0];
  end

  assign busy = v1_r | v2_r | v3_r;
  assign acc  = acc_r;
endmodule
`default_nettype wire

// File: tb/quadratic_form_checker.sv
// Scoreboard for the quadratic form engine: predicts evaluate results and compares them.
`timescale 1ns / 1ps
module quadratic_form_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [2:0]                          in_req_type,
  input  logic [7:0]                          in_row_mask,
  input  logic [7:0]                          in_col_mask,
  input  logic [2:0]                          in_var_index,
  input  logic signed [15:0]                  in_var_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [qfe_pkg::OUT_BITS-1:0] out_form_value,
  output int                                  error_count,
  output int                                  pending_forms
);
  import qfe_pkg::*;

  localparam longint FORM_MAX = (64'sd1 <<< (OUT_BITS - 1)) - 1;
  localparam longint FORM_MIN = -FORM_MAX - 1;
  localparam longint COEF_MAX = (64'sd1 <<< (COEF_BITS_D - 1)) - 1;
  localparam longint COEF_MIN = -COEF_MAX - 1;
  localparam longint VAL_MAX  = (64'sd1 <<< (VALUE_BITS_D - 1)) - 1;
  localparam longint VAL_MIN  = -VAL_MAX - 1;

  longint coef_q[NUM_VARS_D][NUM_VARS_D];
  longint var_q[NUM_VARS_D];
  logic signed [OUT_BITS-1:0] form_q[$];

  assign pending_forms = form_q.size();

  function automatic longint clamp_form(longint v);
    if (v > FORM_MAX) return FORM_MAX;
    if (v < FORM_MIN) return FORM_MIN;
    return v;
  endfunction

  // Products fit in 64 bits at default sizes (16b coef * 32b square).
  function automatic longint eval_form();
    longint acc;
    acc = 0;
    for (int i = 0; i < NUM_VARS_D; i++)
      for (int j = 0; j < NUM_VARS_D; j++)
        acc = clamp_form(acc + clamp_form(coef_q[i][j] * var_q[i] * var_q[j]));
    return acc;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  initial error_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (coef_q[i, j]) coef_q[i][j] = 0;
      foreach (var_q[i]) var_q[i] = 0;
      form_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (form_q.size() == 0) begin
          report_mismatch("unexpected word", out_form_value, 0);
        end else begin
          if (out_form_value !== form_q[0])
            report_mismatch("form_value", out_form_value, form_q[0]);
          void'(form_q.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        case (in_req_type)
          REQ_ADD, REQ_SUB: begin
            for (int i = 0; i < NUM_VARS_D; i++)
              for (int j = 0; j < NUM_VARS_D; j++)
                if (in_row_mask[i] && in_col_mask[j]) begin
                  coef_q[i][j] += (in_req_type == REQ_ADD) ? 1 : -1;
                  if (coef_q[i][j] > COEF_MAX) coef_q[i][j] = COEF_MAX;
                  if (coef_q[i][j] < COEF_MIN) coef_q[i][j] = COEF_MIN;
                end
          end
          REQ_CLR: foreach (coef_q[i, j]) coef_q[i][j] = 0;
          REQ_LOAD: begin
            if (in_var_index < NUM_VARS_D) begin
              var_q[in_var_index] = in_var_value;
              if (var_q[in_var_index] > VAL_MAX) var_q[in_var_index] = VAL_MAX;
              if (var_q[in_var_index] < VAL_MIN) var_q[in_var_index] = VAL_MIN;
            end
          end
          REQ_EVAL: form_q.insert(form_q.size(), eval_form());
          default: ;
        endcase
      end
    end
  end
endmodule

// File: tb/quadratic_form_engine_test.sv
// Top of the quadratic form engine testbench: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module quadratic_form_engine_test;
  import qfe_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_req_type;
  logic [7:0] in_row_mask;
  logic [7:0] in_col_mask;
  logic [2:0] in_var_index;
  logic signed [15:0] in_var_value;
  logic out_valid;
  logic out_ready;
  logic signed [OUT_BITS-1:0] out_form_value;
  int error_count;
  int pending_forms;

  // Idle percentages for each side; the phase switch rewrites them.
  int send_idle_pct;
  int recv_idle_pct;
  // Set to make the receiver hold off for a long run of cycles.
  logic recv_hold;
  int hold_cycles;

  quadratic_form_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_row_mask(in_row_mask),
    .in_col_mask(in_col_mask), .in_var_index(in_var_index),
    .in_var_value(in_var_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_form_value(out_form_value)
  );

  quadratic_form_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_row_mask(in_row_mask),
    .in_col_mask(in_col_mask), .in_var_index(in_var_index),
    .in_var_value(in_var_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_form_value(out_form_value),
    .error_count(error_count), .pending_forms(pending_forms)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound: 554 items, about a fifth of them evaluates, plus stalls.
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random stalls, or a solid hold-off when recv_hold is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Drive one word and hold it until the block takes it; drop valid while idling.
  task automatic send_word(input logic [2:0] req, input logic [7:0] rows,
                           input logic [7:0] cols, input logic [2:0] idx,
                           input logic [15:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_row_mask  <= rows;
    in_col_mask  <= cols;
    in_var_index <= idx;
    in_var_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Mostly updates and loads with a steady share of evaluates; rare unused codes.
  task automatic send_random_word();
    int pick;
    logic [2:0] req;
    pick = $urandom_range(99);
    if (pick < 30) req = REQ_ADD;
    else if (pick < 45) req = REQ_SUB;
    else if (pick < 48) req = REQ_CLR;
    else if (pick < 73) req = REQ_LOAD;
    else if (pick < 95) req = REQ_EVAL;
    else req = 3'($urandom_range(7, 5));
    send_word(req, 8'($urandom), 8'($urandom), 3'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_forms != 0) @(posedge clk);
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_ADD;
    in_row_mask = '0;
    in_col_mask = '0;
    in_var_index = '0;
    in_var_value = '0;
    recv_hold = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 62;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty form, full and partial masks, extreme loads.
    send_word(REQ_EVAL, 8'h00, 8'h00, 3'd0, 16'h0000);
    send_word(REQ_LOAD, 8'h00, 8'h00, 3'd0, 16'h7FFF);
    send_word(REQ_LOAD, 8'h00, 8'h00, 3'd7, 16'h8000);
    send_word(REQ_LOAD, 8'h00, 8'h00, 3'd3, 16'hFFFF);
    send_word(REQ_ADD, 8'hFF, 8'hFF, 3'd0, 16'h0000);
    send_word(REQ_EVAL, 8'h00, 8'h00, 3'd0, 16'h0000);
    send_word(REQ_SUB, 8'h81, 8'h7E, 3'd0, 16'h0000);
    send_word(REQ_SUB, 8'h00, 8'hFF, 3'd0, 16'h0000);
    send_word(REQ_ADD, 8'hFF, 8'h00, 3'd0, 16'h0000);
    send_word(3'd5, 8'hFF, 8'hFF, 3'd1, 16'h1234);
    send_word(3'd6, 8'hFF, 8'hFF, 3'd2, 16'h5555);
    send_word(3'd7, 8'hAA, 8'h55, 3'd4, 16'hAAAA);
    send_word(REQ_EVAL, 8'hFF, 8'hFF, 3'd7, 16'hFFFF);
    send_word(REQ_CLR, 8'hFF, 8'hFF, 3'd7, 16'hFFFF);
    send_word(REQ_EVAL, 8'h00, 8'h00, 3'd0, 16'h0000);
    send_word(REQ_ADD, 8'h01, 8'h80, 3'd0, 16'h0000);
    send_word(REQ_SUB, 8'h80, 8'h01, 3'd0, 16'h0000);
    send_word(REQ_EVAL, 8'h00, 8'h00, 3'd0, 16'h0000);

    // Phase one: sender idles less, receiver more.
    for (int n = 0; n < 180; n++) send_random_word();
    // Sender pause: drain every pending result before going on.
    wait_drained();

    // Phase two: sender idles more, receiver less.
    send_idle_pct = 62;
    recv_idle_pct = 31;
    for (int n = 0; n < 180; n++) send_random_word();

    // Long receiver hold-off while evaluates keep coming, so the input stalls.
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold <= 1'b1;
    fork
      begin
        hold_cycles = 0;
        while (hold_cycles < 400) begin
          @(posedge clk);
          hold_cycles++;
        end
        recv_hold <= 1'b0;
      end
      begin
        for (int n = 0; n < 6; n++)
          send_word(REQ_EVAL, 8'($urandom), 8'($urandom), 3'($urandom), 16'($urandom));
        in_valid <= 1'b0;
      end
    join
    @(posedge clk);

    // Phase three: no idling on either side.
    for (int n = 0; n < 170; n++) send_random_word();
    in_valid <= 1'b0;

    waited = 0;
    while (pending_forms != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);
    if (error_count == 0 && pending_forms == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: quadratic_form_engine.f
src/qfe_pkg.sv
src/qfe_cell.sv
src/qfe_mac.sv
src/quadratic_form_engine.sv
tb/quadratic_form_checker.sv
tb/quadratic_form_engine_test.sv
